// ----- hdl/quicksort_sort_engine_top_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the sort engine
// Concurrent checks, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef QUICKSORT_SORT_ENGINE_TOP_ASSERT_SVH
`define QUICKSORT_SORT_ENGINE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define QS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sort engine assertion failed");
`define QS_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sort engine assertion failed");
`else
`define QS_ASSERT_IMP(label, ante, cons)
`define QS_ASSERT_NXT(label, ante, cons)
`endif
`endif

// ----- hdl/qsort_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qsort_pkg
// Sizes and controller/datapath command and status types of the sort engine.
// ----------------------------------------------------------------------------
package qsort_pkg;

    localparam int CAPACITY = 64;
    localparam int DATA_W   = 32;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int STK_W    = 2 * IDX_W;

    typedef struct packed {
        logic accept;     // take input words
        logic push_full;  // push the whole batch range
        logic pop;        // pop a range and read its entry
        logic range_ld;   // load lo/hi/j/slot from popped entry
        logic rd_piv;     // read element at hi
        logic piv_ld;     // capture pivot
        logic rd_pair;    // read elements at j and slot
        logic wr_slot;    // write element at j into slot
        logic wr_j;       // write element at slot into j
        logic adv_j;
        logic adv_slot;
        logic push_r;     // push right part of a split range
        logic push_l;     // push left part of a split range
        logic rd_out;     // read element at k
        logic out_ld;     // load output register
        logic adv_k;
        logic batch_clr;
    } cmd_t;

    typedef struct packed {
        logic in_fire;
        logic in_last;
        logic cnt_lt2;
        logic le;
        logic j_eq_hi;
        logic range_bad;
        logic sp_zero;
        logic right_ok;
        logic left_ok;
        logic k_last;
        logic out_fire;
    } sts_t;

endpackage

// ----- hdl/qsort_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qsort_in_if
// Input channel: one batch element per word, last marks the batch end.
// ----------------------------------------------------------------------------
interface qsort_in_if;
    import qsort_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] value;
    logic                     last;

    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);
endinterface

// ----- hdl/qsort_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qsort_out_if
// Output channel: sorted elements in ascending order with batch flags.
// ----------------------------------------------------------------------------
interface qsort_out_if;
    import qsort_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] sorted_value;
    logic                     last_res;
    logic                     dropped;

    modport source (output valid, output sorted_value, output last_res,
                    output dropped, input ready);
    modport sink   (input valid, input sorted_value, input last_res,
                    input dropped, output ready);
endinterface

// ----- hdl/qsort_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qsort_ctrl
// Sequencer for load, Lomuto partition passes over a range stack, and drain.
// ----------------------------------------------------------------------------
module qsort_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  qsort_pkg::sts_t   sts,
    output qsort_pkg::cmd_t   cmd
);
    import qsort_pkg::*;

    typedef enum logic [3:0] {
        S_LOAD,
        S_START,
        S_POP,
        S_RANGE,
        S_PIV_RD,
        S_PIV_LD,
        S_READ,
        S_CMP,
        S_SWP,
        S_PUSH_R,
        S_PUSH_L,
        S_OUT_RD,
        S_OUT_LD,
        S_OUT_WAIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_LOAD:
            begin
                cmd.accept = 1'b1;
                if (sts.in_fire && sts.in_last)
                begin
                    state_next = S_START;
                end
            end
            S_START:
            begin
                if (sts.cnt_lt2)
                begin
                    state_next = S_OUT_RD;
                end
                else
                begin
                    cmd.push_full = 1'b1;
                    state_next    = S_POP;
                end
            end
            S_POP:
            begin
                if (sts.sp_zero)
                begin
                    state_next = S_OUT_RD;
                end
                else
                begin
                    cmd.pop    = 1'b1;
                    state_next = S_RANGE;
                end
            end
            S_RANGE:
            begin
                cmd.range_ld = 1'b1;
                state_next   = S_PIV_RD;
            end
            S_PIV_RD:
            begin
                if (sts.range_bad)
                begin
                    state_next = S_POP;
                end
                else
                begin
                    cmd.rd_piv = 1'b1;
                    state_next = S_PIV_LD;
                end
            end
            S_PIV_LD:
            begin
                cmd.piv_ld = 1'b1;
                state_next = S_READ;
            end
            S_READ:
            begin
                cmd.rd_pair = 1'b1;
                state_next  = S_CMP;
            end
            S_CMP:
            begin
                // the final step swaps the pivot into place unconditionally
                if (sts.j_eq_hi || sts.le)
                begin
                    cmd.wr_slot = 1'b1;
                    state_next  = S_SWP;
                end
                else
                begin
                    cmd.adv_j  = 1'b1;
                    state_next = S_READ;
                end
            end
            S_SWP:
            begin
                cmd.wr_j = 1'b1;
                if (sts.j_eq_hi)
                begin
                    state_next = S_PUSH_R;
                end
                else
                begin
                    cmd.adv_j    = 1'b1;
                    cmd.adv_slot = 1'b1;
                    state_next   = S_READ;
                end
            end
            S_PUSH_R:
            begin
                cmd.push_r = sts.right_ok;
                state_next = S_PUSH_L;
            end
            S_PUSH_L:
            begin
                cmd.push_l = sts.left_ok;
                state_next = S_POP;
            end
            S_OUT_RD:
            begin
                cmd.rd_out = 1'b1;
                state_next = S_OUT_LD;
            end
            S_OUT_LD:
            begin
                cmd.out_ld = 1'b1;
                state_next = S_OUT_WAIT;
            end
            S_OUT_WAIT:
            begin
                if (sts.out_fire)
                begin
                    if (sts.k_last)
                    begin
                        cmd.batch_clr = 1'b1;
                        state_next    = S_LOAD;
                    end
                    else
                    begin
                        cmd.adv_k  = 1'b1;
                        state_next = S_OUT_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

endmodule

// ----- hdl/qsort_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qsort_dp
// Element store, range stack, partition indexes and output register.
// ----------------------------------------------------------------------------
module qsort_dp (
    input  logic              clk,
    input  logic              rst_n,
    input  qsort_pkg::cmd_t   cmd,
    output qsort_pkg::sts_t   sts,
    qsort_in_if.sink          item,
    qsort_out_if.source       result
);
    import qsort_pkg::*;

    logic [DATA_W-1:0] store_mem [CAPACITY];
    logic [STK_W-1:0]  stack_mem [CAPACITY];

    logic [CNT_W-1:0]         count_reg;
    logic                     ovf_reg;
    logic [CNT_W-1:0]         sp_reg;
    logic [IDX_W-1:0]         k_reg;
    logic [IDX_W-1:0]         lo_reg;
    logic [IDX_W-1:0]         hi_reg;
    logic [IDX_W-1:0]         j_reg;
    logic [IDX_W-1:0]         slot_reg;
    logic signed [DATA_W-1:0] pivot_reg;
    logic signed [DATA_W-1:0] rd_a_reg;
    logic signed [DATA_W-1:0] rd_b_reg;
    logic [STK_W-1:0]         stk_rd_reg;
    logic signed [DATA_W-1:0] sorted_value_reg;
    logic                     last_res_reg;
    logic                     dropped_reg;
    logic                     out_valid_reg;

    logic              in_fire;
    logic              out_fire;
    logic              has_room;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic              rd_a_en;
    logic [IDX_W-1:0]  rd_a_addr;
    logic              push_en;
    logic [STK_W-1:0]  push_data;
    logic [IDX_W-1:0]  pop_idx;
    logic [IDX_W-1:0]  last_idx;

    assign in_fire  = item.valid && cmd.accept;
    assign out_fire = out_valid_reg && result.ready;
    assign has_room = count_reg < CNT_W'(CAPACITY);
    assign last_idx = IDX_W'(count_reg - CNT_W'(1));
    assign pop_idx  = IDX_W'(sp_reg - CNT_W'(1));

    // single write port: loading, or one half of a swap
    always_comb
    begin
        wr_en   = (in_fire && has_room) || cmd.wr_slot || cmd.wr_j;
        wr_addr = j_reg;
        wr_data = rd_b_reg;
        if (in_fire)
        begin
            wr_addr = count_reg[IDX_W-1:0];
            wr_data = item.value;
        end
        else if (cmd.wr_slot)
        begin
            wr_addr = slot_reg;
            wr_data = rd_a_reg;
        end
    end

    always_comb
    begin
        rd_a_en   = cmd.rd_pair || cmd.rd_piv || cmd.rd_out;
        rd_a_addr = j_reg;
        if (cmd.rd_piv)
        begin
            rd_a_addr = hi_reg;
        end
        else if (cmd.rd_out)
        begin
            rd_a_addr = k_reg;
        end
    end

    always_comb
    begin
        push_data = {lo_reg, IDX_W'(slot_reg - IDX_W'(1))};
        if (cmd.push_full)
        begin
            push_data = {IDX_W'(0), last_idx};
        end
        else if (cmd.push_r)
        begin
            push_data = {IDX_W'(slot_reg + IDX_W'(1)), hi_reg};
        end
    end

    assign push_en = (cmd.push_full || cmd.push_r || cmd.push_l)
                     && (sp_reg < CNT_W'(CAPACITY));

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= wr_data;
        end
        if (rd_a_en)
        begin
            rd_a_reg <= store_mem[rd_a_addr];
        end
        if (cmd.rd_pair)
        begin
            rd_b_reg <= store_mem[slot_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_en)
        begin
            stack_mem[sp_reg[IDX_W-1:0]] <= push_data;
        end
        if (cmd.pop)
        begin
            stk_rd_reg <= stack_mem[pop_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            sp_reg        <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                if (has_room)
                begin
                    count_reg <= count_reg + CNT_W'(1);
                end
                else
                begin
                    ovf_reg <= 1'b1;
                end
            end
            if (push_en)
            begin
                sp_reg <= sp_reg + CNT_W'(1);
            end
            else if (cmd.pop)
            begin
                sp_reg <= sp_reg - CNT_W'(1);
            end
            if (cmd.adv_k)
            begin
                k_reg <= k_reg + IDX_W'(1);
            end
            if (cmd.out_ld)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_fire)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.batch_clr)
            begin
                count_reg <= '0;
                ovf_reg   <= 1'b0;
                k_reg     <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.range_ld)
        begin
            lo_reg   <= stk_rd_reg[STK_W-1:IDX_W];
            hi_reg   <= stk_rd_reg[IDX_W-1:0];
            j_reg    <= stk_rd_reg[STK_W-1:IDX_W];
            slot_reg <= stk_rd_reg[STK_W-1:IDX_W];
        end
        else
        begin
            if (cmd.adv_j)
            begin
                j_reg <= j_reg + IDX_W'(1);
            end
            if (cmd.adv_slot)
            begin
                slot_reg <= slot_reg + IDX_W'(1);
            end
        end
        if (cmd.piv_ld)
        begin
            pivot_reg <= rd_a_reg;
        end
        if (cmd.out_ld)
        begin
            sorted_value_reg <= rd_a_reg;
            last_res_reg     <= sts.k_last;
            dropped_reg      <= ovf_reg;
        end
    end

    assign sts.in_fire   = in_fire;
    assign sts.in_last   = item.last;
    assign sts.cnt_lt2   = count_reg < CNT_W'(2);
    assign sts.le        = rd_a_reg <= pivot_reg;
    assign sts.j_eq_hi   = j_reg == hi_reg;
    assign sts.range_bad = (lo_reg >= hi_reg) || ({1'b0, hi_reg} >= count_reg);
    assign sts.sp_zero   = sp_reg == '0;
    assign sts.right_ok  = ({1'b0, slot_reg} + CNT_W'(1)) < {1'b0, hi_reg};
    assign sts.left_ok   = {1'b0, slot_reg} > ({1'b0, lo_reg} + CNT_W'(1));
    assign sts.k_last    = ({1'b0, k_reg} + CNT_W'(1)) == count_reg;
    assign sts.out_fire  = out_fire;

    assign item.ready          = cmd.accept;
    assign result.valid        = out_valid_reg;
    assign result.sorted_value = sorted_value_reg;
    assign result.last_res     = last_res_reg;
    assign result.dropped      = dropped_reg;

endmodule

// ----- hdl/quicksort_sort_engine_top.sv -----
`timescale 1ns / 1ps
// Sort engine: collects a batch of signed 32-bit words on the item channel,
// the final word flagged by last, sorts them ascending and returns them on
// the result channel, last_res set on the final one. Both channels move a
// word when valid and ready are high at a rising clk edge.
// Up to 64 words are kept per batch; further words are discarded and every
// result of that batch carries dropped. A batch that ends in a discarded
// word is still closed by it.
// Loading takes one word per cycle. The sort is a Lomuto quicksort over a
// stack of pending ranges: each element of a range is read and compared
// with the pivot, and each swap writes its two elements one after the
// other through the single write port of the element memory. Draining
// reads each word into the output register and waits for it to be taken.
// The item channel is ready only while a batch is loading; once the final
// result has been taken it is ready again in the next cycle.
// A stalled receiver holds the current result in the output register and
// the engine waits. Reset returns the engine to an empty batch, ready.
// ----------------------------------------------------------------------------
// quicksort_sort_engine_top
// Batch sort engine: controller and datapath.
// ----------------------------------------------------------------------------
`include "quicksort_sort_engine_top_assert.svh"

module quicksort_sort_engine_top (
    input  logic         clk,
    input  logic         rst_n,
    qsort_in_if.sink     item,
    qsort_out_if.source  result
);
    import qsort_pkg::*;

    cmd_t cmd;
    sts_t sts;

    qsort_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    qsort_dp u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .sts    (sts),
        .item   (item),
        .result (result)
    );

    // loading and draining never overlap
    `QS_ASSERT_IMP(a_no_load_while_result, item.ready, !result.valid)
    // the range stack is empty whenever a batch is loading
    `QS_ASSERT_IMP(a_stack_empty_on_load, item.ready, sts.sp_zero)
    // the final result hands the engine back to loading
    `QS_ASSERT_NXT(a_reload_after_last,
                   result.valid && result.ready && result.last_res, item.ready)

endmodule

// ----- bench/quicksort_sort_engine_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quicksort_sort_engine_top_tb
// Sends batches of signed words to the sort engine and checks each
// sorted word, including its last_res and dropped flags, against an
// in-bench quicksort of the same batch. Batches range from one word to
// past the store depth, and both channels stall at random.
// ----------------------------------------------------------------------------
module quicksort_sort_engine_top_tb;
    import qsort_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_WORDS = 385;
    localparam int SETTLE       = 40;

    typedef struct {
        logic signed [DATA_W-1:0] value;
        logic                     last_res;
        logic                     dropped;
    } sorted_word_t;

    typedef struct {
        int lo;
        int hi;
    } span_t;

    typedef enum {
        FILL_RANDOM,
        FILL_ASCENDING,
        FILL_DESCENDING,
        FILL_FEW_DISTINCT,
        FILL_NEAR_LIMITS
    } fill_t;

    class sort_scoreboard;
        logic signed [DATA_W-1:0] store [CAPACITY];
        int                       held;
        bit                       lost_words;
        sorted_word_t             expected_q[$];
        int                       mismatches;
        int                       words_in;
        int                       words_checked;
        int                       batches;
        int                       overflow_batches;

        function new();
            held             = 0;
            lost_words       = 1'b0;
            mismatches       = 0;
            words_in         = 0;
            words_checked    = 0;
            batches          = 0;
            overflow_batches = 0;
        endfunction

        // Lomuto partition, last element as pivot, explicit stack of ranges
        function void sort_held();
            span_t                    pending[$];
            span_t                    span;
            logic signed [DATA_W-1:0] pivot;
            logic signed [DATA_W-1:0] tmp;
            int                       slot;
            if (held < 2)
                return;
            pending.push_back('{0, held - 1});
            while (pending.size() > 0)
            begin
                span = pending.pop_back();
                if (span.lo >= span.hi)
                    continue;
                pivot = store[span.hi];
                slot  = span.lo;
                for (int j = span.lo; j < span.hi; j++)
                begin
                    if (store[j] <= pivot)
                    begin
                        tmp         = store[slot];
                        store[slot] = store[j];
                        store[j]    = tmp;
                        slot++;
                    end
                end
                tmp            = store[slot];
                store[slot]    = store[span.hi];
                store[span.hi] = tmp;
                if (slot + 1 < span.hi)
                    pending.push_back('{slot + 1, span.hi});
                if (slot > span.lo + 1)
                    pending.push_back('{span.lo, slot - 1});
            end
        endfunction

        function void note_word(logic signed [DATA_W-1:0] v, logic fin);
            sorted_word_t w;
            words_in++;
            // drop anything past the store depth, but remember it
            if (held < CAPACITY)
            begin
                store[held] = v;
                held++;
            end
            else
                lost_words = 1'b1;
            if (fin)
            begin
                sort_held();
                for (int k = 0; k < held; k++)
                begin
                    w.value    = store[k];
                    w.last_res = (k == held - 1);
                    w.dropped  = lost_words;
                    expected_q.push_back(w);
                end
                batches++;
                if (lost_words)
                    overflow_batches++;
                held       = 0;
                lost_words = 1'b0;
            end
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            if (mismatches <= 40)
                $display("MISMATCH @%0t word %0d: %s", $time, words_checked, msg);
        endtask

        task check_result(logic signed [DATA_W-1:0] v, logic fin, logic lost);
            sorted_word_t w;
            words_checked++;
            if (expected_q.size() == 0)
            begin
                report_mismatch($sformatf("unexpected word %0d", v));
                return;
            end
            w = expected_q.pop_front();
            if (v !== w.value)
                report_mismatch($sformatf("sorted_value %0d, want %0d", v, w.value));
            if (fin !== w.last_res)
                report_mismatch($sformatf("last_res %b, want %b", fin, w.last_res));
            if (lost !== w.dropped)
                report_mismatch($sformatf("dropped %b, want %b", lost, w.dropped));
        endtask
    endclass

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    qsort_in_if  item_ch ();
    qsort_out_if result_ch ();

    quicksort_sort_engine_top uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch)
    );

    sort_scoreboard sb;
    int             cycle_count  = 0;
    int             burst_left   = 0;
    bit             steady       = 1'b0;
    logic [15:0]    ready_pattern = 16'hFFFF;
    int             ready_hold   = 0;
    int             limit_vals [6] = '{int'(32'h8000_0000), int'(32'h8000_0001), -1, 0,
                                       int'(32'h7FFF_FFFE), int'(32'h7FFF_FFFF)};

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d words still expected",
                     cycle_count, sb.expected_q.size());
            $display("quicksort_sort_engine_top_tb NOT OK");
            $finish;
        end
    end

    // receiver: rotate a stall pattern, pick a new one now and then
    always @(posedge clk)
    begin
        if (ready_hold == 0)
        begin
            ready_hold <= $urandom_range(20, 200);
            case ($urandom_range(0, 3))
                0:       ready_pattern <= 16'hFFFF;
                1:       ready_pattern <= 16'h0101;
                default: ready_pattern <= 16'(($urandom | 32'h1));
            endcase
        end
        else
        begin
            ready_hold    <= ready_hold - 1;
            ready_pattern <= {ready_pattern[0], ready_pattern[15:1]};
        end
        result_ch.ready <= ready_pattern[0];
    end

    always @(posedge clk)
    begin
        if (rst_n && item_ch.valid && item_ch.ready)
            sb.note_word(item_ch.value, item_ch.last);
        if (rst_n && result_ch.valid && result_ch.ready)
            sb.check_result(result_ch.sorted_value, result_ch.last_res, result_ch.dropped);
    end

    task automatic pace();
        int gap;
        if (steady)
            return;
        if (burst_left > 0)
        begin
            burst_left--;
            return;
        end
        burst_left = $urandom_range(0, 11);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_word(int v, bit fin);
        item_ch.valid <= 1'b1;
        item_ch.value <= v;
        item_ch.last  <= fin;
        do
            @(posedge clk);
        while (item_ch.ready !== 1'b1);
        pace();
    endtask

    task automatic send_batch(input int vals[$]);
        foreach (vals[i])
            send_word(vals[i], i == vals.size() - 1);
    endtask

    // hold the sender until every sorted word has come back
    task automatic wait_drained();
        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_q.size() != 0)
            @(posedge clk);
    endtask

    function automatic void make_batch(int len, fill_t fill, ref int vals[$]);
        int palette[$];
        vals.delete();
        repeat (3) palette.push_back(int'($urandom));
        for (int i = 0; i < len; i++)
        begin
            case (fill)
                FILL_FEW_DISTINCT: vals.push_back(palette[$urandom_range(0, 2)]);
                FILL_NEAR_LIMITS:  vals.push_back(limit_vals[$urandom_range(0, 5)]);
                default:           vals.push_back(int'($urandom));
            endcase
        end
        if (fill == FILL_ASCENDING)
            vals.sort();
        else if (fill == FILL_DESCENDING)
            vals.rsort();
    endfunction

    initial
    begin
        int    vals[$];
        int    len;
        int    pick;
        int    random_words;
        fill_t fill;

        sb = new();
        item_ch.valid   <= 1'b0;
        item_ch.value   <= '0;
        item_ch.last    <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: single-word batches at both limits, mixed extremes,
        // duplicates, already sorted and reverse sorted
        vals = '{int'(32'h8000_0000)};
        send_batch(vals);
        vals = '{int'(32'h7FFF_FFFF)};
        send_batch(vals);
        vals = '{int'(32'h7FFF_FFFF), int'(32'h8000_0000), 0, -1, 1,
                 int'(32'h8000_0001), int'(32'h7FFF_FFFE)};
        send_batch(vals);
        vals = '{-5, 3, -5, 3, -5};
        send_batch(vals);
        vals = '{1, 2, 3, 4};
        send_batch(vals);
        vals = '{4, 3, 2, 1};
        send_batch(vals);
        wait_drained();

        // random: a full store and a one-over batch first, then a mix
        random_words = 0;
        make_batch(CAPACITY, FILL_RANDOM, vals);
        send_batch(vals);
        random_words += vals.size();
        make_batch(CAPACITY + 1, FILL_ASCENDING, vals);
        send_batch(vals);
        random_words += vals.size();
        while (random_words < RANDOM_WORDS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
                len = $urandom_range(1, 8);
            else if (pick < 80)
                len = $urandom_range(9, 24);
            else if (pick < 88)
                len = 2;
            else if (pick < 94)
                len = CAPACITY;
            else
                len = $urandom_range(CAPACITY + 1, CAPACITY + 6);
            fill   = fill_t'($urandom_range(0, 4));
            steady = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 9) == 0)
                wait_drained();
            make_batch(len, fill, vals);
            send_batch(vals);
            random_words += len;
        end

        wait_drained();
        repeat (SETTLE) @(posedge clk);

        $display("Ran %0d batches (%0d past the store depth) from %0d words in",
                 sb.batches, sb.overflow_batches, sb.words_in);
        $display("Checked %0d sorted words, %0d mismatches, %0d still expected",
                 sb.words_checked, sb.mismatches, sb.expected_q.size());
        if (sb.mismatches == 0 && sb.expected_q.size() == 0)
            $display("quicksort_sort_engine_top_tb OK");
        else
            $display("quicksort_sort_engine_top_tb NOT OK");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/qsort_pkg.sv
hdl/qsort_in_if.sv
hdl/qsort_out_if.sv
hdl/qsort_ctrl.sv
hdl/qsort_dp.sv
hdl/quicksort_sort_engine_top.sv
bench/quicksort_sort_engine_top_tb.sv
